### design/lsfe_pkg.sv
// lsfe_pkg: shared types, constants and fade arithmetic for the led strip fade engine
// used by the front, back and top level; depends on nothing
package lsfe_pkg;

  // default sizes handed to the top level
  localparam int unsigned PIXEL_COUNT_DEF   = 42;
  localparam int unsigned SEGMENT_COUNT_DEF = 4;
  localparam int unsigned FADE_STEP_DEF     = 3;

  // fixed field widths
  localparam int unsigned POS_W     = 6;
  localparam int unsigned SEG_W     = 2;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned GRB_W     = 24;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned REG_IDX_W = 4;

  // queue depths
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  // segment register map
  localparam int unsigned MAX_SEGMENTS = 4;
  localparam logic [REG_IDX_W-1:0] REG_SEG0_FIRST = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEG0_LAST  = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEG1_FIRST = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEG1_LAST  = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEG2_FIRST = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEG2_LAST  = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_SEG3_FIRST = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_SEG3_LAST  = 4'd7;

  // segment reset bounds that do not depend on the strip length
  localparam logic [POS_W-1:0] SEG0_FIRST_RST = 6'd0;
  localparam logic [POS_W-1:0] SEG1_FIRST_RST = 6'd0;
  localparam logic [POS_W-1:0] SEG1_LAST_RST  = 6'd5;
  localparam logic [POS_W-1:0] SEG2_FIRST_RST = 6'd6;
  localparam logic [POS_W-1:0] SEG2_LAST_RST  = 6'd15;
  localparam logic [POS_W-1:0] SEG3_FIRST_RST = 6'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_PIXEL    = 3'd0,
    KIND_SET_TARGET   = 3'd1,
    KIND_FILL_SEGMENT = 3'd2,
    KIND_DRAW         = 3'd3,
    KIND_CLEAR        = 3'd4
  } lsfe_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SWEEP
  } lsfe_state_e;

  // host request as it arrives
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pixel_position;
    logic [SEG_W-1:0]  segment_number;
    logic [CHAN_W-1:0] red_level;
    logic [CHAN_W-1:0] green_level;
    logic [CHAN_W-1:0] blue_level;
  } lsfe_cmd_t;

  // one emitted pixel
  typedef struct packed {
    logic [GRB_W-1:0] pixel_grb;
    logic [POS_W-1:0] pixel_slot;
    logic             frame_end;
    logic             fade_pending;
  } lsfe_res_t;

  // classified operation; for pixel writes and fills first..last is an in-range, non-empty pixel span
  typedef struct packed {
    lsfe_kind_e       kind;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic [GRB_W-1:0] grb;
  } lsfe_op_t;

  // move one channel toward its target by at most step
  function automatic logic [CHAN_W-1:0] lsfe_approach(input logic [CHAN_W-1:0] cur,
                                                       input logic [CHAN_W-1:0] dst,
                                                       input logic [CHAN_W-1:0] step);
    logic [CHAN_W-1:0] gap;
    logic [CHAN_W-1:0] move;
    gap  = (dst > cur) ? (dst - cur) : (cur - dst);
    move = (gap > step) ? step : gap;
    return (dst > cur) ? (cur + move) : (cur - move);
  endfunction

  function automatic logic [GRB_W-1:0] lsfe_fade(input logic [GRB_W-1:0]  cur,
                                                  input logic [GRB_W-1:0]  dst,
                                                  input logic [CHAN_W-1:0] step);
    return {lsfe_approach(cur[23:16], dst[23:16], step),
            lsfe_approach(cur[15:8],  dst[15:8],  step),
            lsfe_approach(cur[7:0],   dst[7:0],   step)};
  endfunction

endpackage

### design/lsfe_fifo.sv
// lsfe_fifo: small register queue with count, used for operations and for results
// standalone, payload type given by parameter
module lsfe_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/lsfe_front.sv
// lsfe_front: segment registers and request classification
// depends on lsfe_pkg; feeds the operation queue
module lsfe_front
  import lsfe_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT   = PIXEL_COUNT_DEF,
  parameter int unsigned SEGMENT_COUNT = SEGMENT_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  lsfe_cmd_t            cmd_i,
  output logic                 op_push_o,
  output lsfe_op_t             op_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(PIXEL_COUNT - 1);
  localparam logic [POS_W:0]   Count   = (POS_W + 1)'(PIXEL_COUNT);
  localparam logic [SEG_W:0]   SegCnt  = (SEG_W + 1)'(SEGMENT_COUNT);

  logic [POS_W-1:0] seg_first_q [MAX_SEGMENTS];
  logic [POS_W-1:0] seg_last_q  [MAX_SEGMENTS];
  logic [POS_W-1:0] sel_first, sel_last, stop;
  logic             keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_first_q[0] <= SEG0_FIRST_RST;
      seg_last_q[0]  <= LastPos;
      seg_first_q[1] <= SEG1_FIRST_RST;
      seg_last_q[1]  <= SEG1_LAST_RST;
      seg_first_q[2] <= SEG2_FIRST_RST;
      seg_last_q[2]  <= SEG2_LAST_RST;
      seg_first_q[3] <= SEG3_FIRST_RST;
      seg_last_q[3]  <= LastPos;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SEG0_FIRST: seg_first_q[0] <= cfg_data_i;
        REG_SEG0_LAST:  seg_last_q[0]  <= cfg_data_i;
        REG_SEG1_FIRST: seg_first_q[1] <= cfg_data_i;
        REG_SEG1_LAST:  seg_last_q[1]  <= cfg_data_i;
        REG_SEG2_FIRST: seg_first_q[2] <= cfg_data_i;
        REG_SEG2_LAST:  seg_last_q[2]  <= cfg_data_i;
        REG_SEG3_FIRST: seg_first_q[3] <= cfg_data_i;
        REG_SEG3_LAST:  seg_last_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sel_first = seg_first_q[cmd_i.segment_number];
  assign sel_last  = seg_last_q[cmd_i.segment_number];
  // clip the segment to the strip
  assign stop      = ({1'b0, sel_last} >= Count) ? LastPos : sel_last;

  always_comb begin
    op_o.kind  = lsfe_kind_e'(cmd_i.kind);
    op_o.first = cmd_i.pixel_position;
    op_o.last  = cmd_i.pixel_position;
    op_o.grb   = {cmd_i.green_level, cmd_i.red_level, cmd_i.blue_level};
    keep       = 1'b0;
    case (cmd_i.kind)
      KIND_SET_PIXEL, KIND_SET_TARGET: begin
        keep = ({1'b0, cmd_i.pixel_position} < Count);
      end
      KIND_FILL_SEGMENT: begin
        op_o.first = sel_first;
        op_o.last  = stop;
        keep       = ({1'b0, cmd_i.segment_number} < SegCnt) &&
                     ({1'b0, sel_first} < Count) && (sel_first <= stop);
      end
      KIND_DRAW, KIND_CLEAR: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // dropped requests are accepted but never queued
  assign op_push_o = accept_i && keep;

endmodule

### design/lsfe_back.sv
// lsfe_back: colour memories, write/fill sequencer and draw/clear sweep with fade writeback
// depends on lsfe_pkg; drains the operation queue, fills the result queue
module lsfe_back
  import lsfe_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT = PIXEL_COUNT_DEF,
  parameter int unsigned FADE_STEP   = FADE_STEP_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_valid_i,
  input  lsfe_op_t                         op_i,
  output logic                             op_pop_o,
  input  logic [$clog2(RES_DEPTH+1)-1:0]   res_count_i,
  output logic                             res_push_o,
  output lsfe_res_t                        res_o
);

  localparam int unsigned      AddrW   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned      CntW    = $clog2(RES_DEPTH + 1);
  localparam logic [POS_W-1:0] LastPos = POS_W'(PIXEL_COUNT - 1);
  localparam logic [CHAN_W-1:0] Step   = CHAN_W'(FADE_STEP);

  logic [GRB_W-1:0]       cur_mem [PIXEL_COUNT];
  logic [GRB_W-1:0]       tgt_mem [PIXEL_COUNT];
  logic [PIXEL_COUNT-1:0] cur_vld_q, tgt_vld_q;

  lsfe_state_e      state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] last_q, last_d;
  logic [GRB_W-1:0] grb_q, grb_d;
  lsfe_kind_e       sweep_kind_q, sweep_kind_d;
  logic             changed_q, changed_d;

  logic             s2_valid_q, s2_valid_d;
  logic [POS_W-1:0] s2_slot_q, s2_slot_d;
  logic             s2_last_q, s2_last_d;
  lsfe_kind_e       s2_kind_q, s2_kind_d;
  logic [GRB_W-1:0] cur_rd_q, tgt_rd_q;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             cur_we, tgt_we;
  logic [AddrW-1:0] cur_waddr, tgt_waddr;
  logic [GRB_W-1:0] cur_wdata, tgt_wdata;
  logic [GRB_W-1:0] faded;
  logic             differs;
  logic             room;

  assign faded   = lsfe_fade(cur_rd_q, tgt_rd_q, Step);
  assign differs = (cur_rd_q != tgt_rd_q);
  // one slot for the pixel in flight, one for the pixel issued now
  assign room    = ((CntW + 1)'(res_count_i) + (CntW + 1)'(s2_valid_q)) <
                   (CntW + 1)'(RES_DEPTH);
  assign rd_addr = cnt_q[AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    grb_d        = grb_q;
    sweep_kind_d = sweep_kind_q;
    changed_d    = changed_q;
    s2_valid_d   = 1'b0;
    s2_slot_d    = s2_slot_q;
    s2_last_d    = s2_last_q;
    s2_kind_d    = s2_kind_q;
    op_pop_o     = 1'b0;
    rd_en        = 1'b0;
    cur_we       = 1'b0;
    tgt_we       = 1'b0;
    cur_waddr    = s2_slot_q[AddrW-1:0];
    tgt_waddr    = s2_slot_q[AddrW-1:0];
    cur_wdata    = '0;
    tgt_wdata    = '0;

    // pixel read last cycle: emit it and write back
    res_push_o         = s2_valid_q;
    res_o.pixel_slot   = s2_slot_q;
    res_o.frame_end    = s2_last_q;
    res_o.pixel_grb    = cur_rd_q;
    res_o.fade_pending = 1'b0;
    if (s2_valid_q) begin
      if (s2_kind_q == KIND_CLEAR) begin
        res_o.pixel_grb = '0;
        cur_we          = 1'b1;
        tgt_we          = 1'b1;
      end else begin
        res_o.fade_pending = s2_last_q && (changed_q || differs);
        cur_we             = differs;
        cur_wdata          = faded;
        changed_d          = changed_q || differs;
      end
    end

    case (state_q)
      ST_IDLE: begin
        // wait for the sweep writeback so the write ports are free
        if (op_valid_i && !s2_valid_q) begin
          op_pop_o = 1'b1;
          case (op_i.kind)
            KIND_SET_PIXEL: begin
              cur_we    = 1'b1;
              tgt_we    = 1'b1;
              cur_waddr = op_i.first[AddrW-1:0];
              tgt_waddr = op_i.first[AddrW-1:0];
              cur_wdata = op_i.grb;
              tgt_wdata = op_i.grb;
            end
            KIND_SET_TARGET: begin
              tgt_we    = 1'b1;
              tgt_waddr = op_i.first[AddrW-1:0];
              tgt_wdata = op_i.grb;
            end
            KIND_FILL_SEGMENT: begin
              state_d = ST_FILL;
              cnt_d   = op_i.first;
              last_d  = op_i.last;
              grb_d   = op_i.grb;
            end
            KIND_DRAW, KIND_CLEAR: begin
              state_d      = ST_SWEEP;
              cnt_d        = '0;
              sweep_kind_d = op_i.kind;
              changed_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        tgt_we    = 1'b1;
        tgt_waddr = cnt_q[AddrW-1:0];
        tgt_wdata = grb_q;
        if (cnt_q == last_q) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SWEEP: begin
        if (room) begin
          rd_en      = 1'b1;
          s2_valid_d = 1'b1;
          s2_slot_d  = cnt_q;
          s2_last_d  = (cnt_q == LastPos);
          s2_kind_d  = sweep_kind_q;
          if (cnt_q == LastPos) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s2_valid_q <= 1'b0;
      changed_q  <= 1'b0;
      cur_vld_q  <= '0;
      tgt_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      s2_valid_q <= s2_valid_d;
      changed_q  <= changed_d;
      if (cur_we) begin
        cur_vld_q[cur_waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_q[tgt_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    last_q       <= last_d;
    grb_q        <= grb_d;
    sweep_kind_q <= sweep_kind_d;
    s2_slot_q    <= s2_slot_d;
    s2_last_q    <= s2_last_d;
    s2_kind_q    <= s2_kind_d;
  end

  // colour memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (rd_en) begin
      cur_rd_q <= cur_vld_q[rd_addr] ? cur_mem[rd_addr] : '0;
      tgt_rd_q <= tgt_vld_q[rd_addr] ? tgt_mem[rd_addr] : '0;
    end
  end

endmodule

### design/led_strip_fade_engine_unit.sv
// led_strip_fade_engine_unit: top level of the led strip fade engine
// depends on lsfe_pkg, lsfe_fifo, lsfe_front and lsfe_back
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   request  | in        | push / full               | cmd_i  (lsfe_cmd_t)
//   result   | out       | empty / pop               | res_o  (lsfe_res_t)
//   config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// draw and clear read one pixel a cycle while the result queue has room, through
// the single read port of each colour memory, then emit and write back each pixel
// set pixel and set target write when popped; fill writes its span pixel by pixel
// reset clears the colours through per-entry valid bits at once; no clearing pass
// a full result queue stalls the sweep; requests keep queueing until the
// operation queue is full
module led_strip_fade_engine_unit
  import lsfe_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT   = PIXEL_COUNT_DEF,
  parameter int unsigned SEGMENT_COUNT = SEGMENT_COUNT_DEF,
  parameter int unsigned FADE_STEP     = FADE_STEP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 push,
  input  lsfe_cmd_t            cmd_i,
  output logic                 full,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output lsfe_res_t            res_o,
  // segment registers
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i
);

  localparam int unsigned ResCntW = $clog2(RES_DEPTH + 1);

  // front to operation queue
  logic      op_push;
  lsfe_op_t  op_in;
  // operation queue to back
  lsfe_op_t  op_out;
  logic      op_empty;
  logic      op_pop;
  // back to result queue
  logic               res_push;
  lsfe_res_t          res_in;
  logic               res_full;
  logic [ResCntW-1:0] res_count;

  // request accepted: classified, and queued unless it does nothing
  lsfe_front #(
    .PIXEL_COUNT   (PIXEL_COUNT),
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .cmd_i       (cmd_i),
    .op_push_o   (op_push),
    .op_o        (op_in),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // short queue decoupling the front from the sequencer
  lsfe_fifo #(
    .T     (lsfe_op_t),
    .DEPTH (CMD_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .full_o  (full),
    .empty_o (op_empty),
    .count_o ()
  );

  // memories, fill sequencer and draw/clear sweep
  lsfe_back #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .FADE_STEP   (FADE_STEP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue; the sweep only issues a pixel when a slot is reserved
  lsfe_fifo #(
    .T     (lsfe_res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_o),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  // the sweep never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed while result queue full");

  // the back only takes an operation that is queued
  assert property (@(posedge clk_i) disable iff (!rst_ni) op_pop |-> !op_empty)
    else $error("operation popped from empty queue");

  // frame end sits on the last strip position only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && res_o.frame_end) |-> (res_o.pixel_slot == POS_W'(PIXEL_COUNT - 1)))
    else $error("frame end on wrong pixel");

  // fade flag only on the last pixel of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_push && res_in.fade_pending) |-> res_in.frame_end)
    else $error("fade pending before frame end");

endmodule

### tb/led_strip_fade_engine_unit_test.sv
// led_strip_fade_engine_unit_test: self-checking bench for the led strip fade engine
// predicts every emitted pixel from its own copy of the colour and segment state
// depends on lsfe_pkg and led_strip_fade_engine_unit
module led_strip_fade_engine_unit_test;
  import lsfe_pkg::*;

  localparam int N_PIXELS   = PIXEL_COUNT_DEF;
  localparam int N_SEGMENTS = SEGMENT_COUNT_DEF;
  localparam int STEP       = FADE_STEP_DEF;
  localparam int N_REGS     = REG_SEG3_LAST + 1;

  // write commands can sit queued behind a sweep; allow a few full fills
  localparam int SETTLE_CYCLES = 4 * (N_PIXELS + 8);
  localparam int STALL_LIMIT   = 4000;

  // request counts at which each random phase hands over
  localparam int FADE_GOAL   = 130;
  localparam int NOISE_GOAL  = 150;
  localparam int STEADY_GOAL = 172;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 push;
  lsfe_cmd_t            req_cmd;
  logic                 full;
  logic                 empty;
  logic                 pop;
  lsfe_res_t            res_pixel;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0]     cfg_data;

  always #5 clk = ~clk;

  led_strip_fade_engine_unit #(
    .PIXEL_COUNT  (N_PIXELS),
    .SEGMENT_COUNT(N_SEGMENTS),
    .FADE_STEP    (STEP)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .cmd_i      (req_cmd),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_pixel),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // shadow of the strip and the segment registers
  logic [GRB_W-1:0] strip_now  [N_PIXELS];
  logic [GRB_W-1:0] strip_goal [N_PIXELS];
  logic [POS_W-1:0] seg_bound  [N_REGS];
  lsfe_res_t        pixels_due [$];
  bit               fade_active;

  int  mismatches;
  int  requests_sent;
  int  pixels_seen;
  int  reg_writes;
  int  fade_runs;
  int  fade_rests;
  bit  calm_run;
  int  stall_left;
  int  idle_cycles;

  function automatic void reset_shadow();
    for (int i = 0; i < N_PIXELS; i++) begin
      strip_now[i]  = '0;
      strip_goal[i] = '0;
    end
    seg_bound[REG_SEG0_FIRST] = SEG0_FIRST_RST;
    seg_bound[REG_SEG0_LAST]  = POS_W'(N_PIXELS - 1);
    seg_bound[REG_SEG1_FIRST] = SEG1_FIRST_RST;
    seg_bound[REG_SEG1_LAST]  = SEG1_LAST_RST;
    seg_bound[REG_SEG2_FIRST] = SEG2_FIRST_RST;
    seg_bound[REG_SEG2_LAST]  = SEG2_LAST_RST;
    seg_bound[REG_SEG3_FIRST] = SEG3_FIRST_RST;
    seg_bound[REG_SEG3_LAST]  = POS_W'(N_PIXELS - 1);
    fade_active = 1'b0;
  endfunction

  // true signed gap, clamped to the fade step
  function automatic logic [CHAN_W-1:0] step_toward(input logic [CHAN_W-1:0] cur,
                                                    input logic [CHAN_W-1:0] dst);
    int gap;
    gap = int'(dst) - int'(cur);
    if (gap > STEP) gap = STEP;
    if (gap < -STEP) gap = -STEP;
    return CHAN_W'(int'(cur) + gap);
  endfunction

  // one frame of the current colours, pending flag only on the last pixel
  function automatic void queue_frame(input bit pending);
    lsfe_res_t px;
    for (int i = 0; i < N_PIXELS; i++) begin
      px.pixel_grb    = strip_now[i];
      px.pixel_slot   = POS_W'(i);
      px.frame_end    = (i == N_PIXELS - 1);
      px.fade_pending = (i == N_PIXELS - 1) ? pending : 1'b0;
      pixels_due.push_back(px);
    end
  endfunction

  function automatic void predict_request(input lsfe_cmd_t c);
    logic [GRB_W-1:0] colour;
    int lo;
    int hi;
    bit moved;
    colour = {c.green_level, c.red_level, c.blue_level};
    case (c.kind)
      KIND_SET_PIXEL: begin
        if (c.pixel_position < N_PIXELS) begin
          strip_now[c.pixel_position]  = colour;
          strip_goal[c.pixel_position] = colour;
        end
      end
      KIND_SET_TARGET: begin
        if (c.pixel_position < N_PIXELS) strip_goal[c.pixel_position] = colour;
      end
      KIND_FILL_SEGMENT: begin
        if (c.segment_number < N_SEGMENTS) begin
          lo = seg_bound[2 * c.segment_number];
          hi = seg_bound[2 * c.segment_number + 1];
          // reversed spans write nothing, slots past the strip are skipped
          for (int i = lo; i <= hi && i < N_PIXELS; i++) strip_goal[i] = colour;
        end
      end
      KIND_DRAW: begin
        moved = 1'b0;
        for (int i = 0; i < N_PIXELS; i++) if (strip_now[i] != strip_goal[i]) moved = 1'b1;
        queue_frame(moved);
        for (int i = 0; i < N_PIXELS; i++) begin
          if (strip_now[i] != strip_goal[i]) begin
            strip_now[i] = {step_toward(strip_now[i][23:16], strip_goal[i][23:16]),
                            step_toward(strip_now[i][15:8],  strip_goal[i][15:8]),
                            step_toward(strip_now[i][7:0],   strip_goal[i][7:0])};
          end
        end
        fade_active = moved;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < N_PIXELS; i++) begin
          strip_now[i]  = '0;
          strip_goal[i] = '0;
        end
        queue_frame(1'b0);
      end
      default: ; // spare kinds do nothing
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_pixel(input lsfe_res_t got);
    lsfe_res_t want;
    pixels_seen++;
    if (pixels_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected pixel, expected none, actual grb %h slot %0d",
               $time, got.pixel_grb, got.pixel_slot);
    end else begin
      want = pixels_due.pop_front();
      compare_field("pixel_grb", want.pixel_grb, got.pixel_grb);
      compare_field("pixel_slot", want.pixel_slot, got.pixel_slot);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("fade_pending", want.fade_pending, got.fade_pending);
    end
  endfunction

  // result side: check what was taken at this edge, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_pixel(res_pixel);
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!calm_run && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d pixels outstanding",
               $time, STALL_LIMIT, pixels_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic lsfe_cmd_t make_request(input logic [KIND_W-1:0] kind,
                                             input logic [POS_W-1:0]  pos,
                                             input logic [SEG_W-1:0]  seg,
                                             input logic [CHAN_W-1:0] red,
                                             input logic [CHAN_W-1:0] green,
                                             input logic [CHAN_W-1:0] blue);
    lsfe_cmd_t c;
    c.kind           = kind;
    c.pixel_position = pos;
    c.segment_number = seg;
    c.red_level      = red;
    c.green_level    = green;
    c.blue_level     = blue;
    return c;
  endfunction

  // given kind, every other field random
  function automatic lsfe_cmd_t any_fields(input logic [KIND_W-1:0] kind);
    return make_request(kind, POS_W'($urandom_range(0, 63)), SEG_W'($urandom_range(0, 3)),
                        CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                        CHAN_W'($urandom_range(0, 255)));
  endfunction

  function automatic logic [CHAN_W-1:0] near_level(input logic [CHAN_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(0, 18)) - 9;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return CHAN_W'(n);
  endfunction

  // push stays high between back-to-back requests
  task automatic send_request(input lsfe_cmd_t c);
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push    <= 1'b1;
    req_cmd <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(c);
    requests_sent++;
  endtask

  // sender holds off until every pixel is back and queued writes are done
  task automatic wait_idle();
    push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_SEG3_LAST) seg_bound[idx] = val;
    reg_writes++;
  endtask

  task automatic program_bounds(input logic [POS_W-1:0] f0, l0, f1, l1, f2, l2, f3, l3);
    logic [POS_W-1:0] v [N_REGS];
    v = '{f0, l0, f1, l1, f2, l2, f3, l3};
    wait_idle();
    for (int r = REG_SEG0_FIRST; r <= REG_SEG3_LAST; r++) write_register(REG_IDX_W'(r), v[r]);
    cfg_valid <= 1'b0;
  endtask

  // clear, fill every segment, then two draws so the filled spans show up
  task automatic exercise_segments();
    send_request(any_fields(KIND_CLEAR));
    for (int s = 0; s < N_SEGMENTS; s++) begin
      send_request(make_request(KIND_FILL_SEGMENT, POS_W'($urandom_range(0, 63)), SEG_W'(s),
                                CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                                CHAN_W'($urandom_range(0, 255))));
    end
    send_request(any_fields(KIND_DRAW));
    send_request(any_fields(KIND_DRAW));
  endtask

  // a few pixels set, targets mostly nudged nearby, then draw until the fade rests or eight draws are sent
  task automatic run_fade_sequence();
    int spots;
    int draws;
    logic [POS_W-1:0]  p;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    if ($urandom_range(0, 2) == 0) send_request(any_fields(KIND_CLEAR));
    spots = $urandom_range(1, 4);
    repeat (spots) begin
      p = POS_W'($urandom_range(0, N_PIXELS - 1));
      r = CHAN_W'($urandom_range(0, 255));
      g = CHAN_W'($urandom_range(0, 255));
      b = CHAN_W'($urandom_range(0, 255));
      send_request(make_request(KIND_SET_PIXEL, p, SEG_W'($urandom_range(0, 3)), r, g, b));
      if ($urandom_range(0, 4) == 0) begin
        send_request(make_request(KIND_SET_TARGET, p, SEG_W'($urandom_range(0, 3)),
                                  CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                                  CHAN_W'($urandom_range(0, 255))));
      end else begin
        send_request(make_request(KIND_SET_TARGET, p, SEG_W'($urandom_range(0, 3)),
                                  near_level(r), near_level(g), near_level(b)));
      end
    end
    if ($urandom_range(0, 5) == 0) send_request(any_fields(KIND_FILL_SEGMENT));
    draws = 0;
    do begin
      send_request(any_fields(KIND_DRAW));
      draws++;
    end while (fade_active && draws < 8);
    fade_runs++;
    if (!fade_active) fade_rests++;
  endtask

  // extremes of position and colour, every kind, ignored positions and spare kinds
  task automatic test_directed_requests();
    send_request(any_fields(KIND_DRAW));
    send_request(make_request(KIND_SET_PIXEL, '0, '0, '1, '1, '1));
    send_request(make_request(KIND_SET_PIXEL, POS_W'(N_PIXELS - 1), '1, '0, '0, '0));
    send_request(make_request(KIND_SET_PIXEL, POS_W'(N_PIXELS), '0, '1, '1, '1));
    send_request(make_request(KIND_SET_PIXEL, '1, '1, 8'h5A, 8'hA5, 8'h3C));
    // full-scale moves in both directions need the true difference
    send_request(make_request(KIND_SET_TARGET, '0, '0, '0, '0, '0));
    send_request(make_request(KIND_SET_TARGET, POS_W'(N_PIXELS - 1), '0, '1, '1, '1));
    send_request(make_request(KIND_SET_TARGET, POS_W'(N_PIXELS), '1, 8'h12, 8'h34, 8'h56));
    send_request(make_request(KIND_SET_TARGET, '1, '0, '1, '0, '1));
    // one-draw move within the step, mixed directions
    send_request(make_request(KIND_SET_PIXEL, POS_W'(20), '0, 8'h10, 8'hF0, 8'h80));
    send_request(make_request(KIND_SET_TARGET, POS_W'(20), '0, 8'h11, 8'hEE, 8'h80));
    send_request(make_request(KIND_FILL_SEGMENT, '0, SEG_W'(1), 8'h55, 8'hAA, 8'h01));
    for (int k = KIND_CLEAR + 1; k < (1 << KIND_W); k++) send_request(any_fields(KIND_W'(k)));
    repeat (3) send_request(any_fields(KIND_DRAW));
    send_request(any_fields(KIND_CLEAR));
    send_request(any_fields(KIND_DRAW));
  endtask

  // default bounds, full and single-pixel spans, reversed and off-strip spans
  task automatic test_segment_bounds();
    exercise_segments();
    program_bounds(6'd0, 6'd41, 6'd41, 6'd41, 6'd0, 6'd0, 6'd40, 6'd63);
    exercise_segments();
    // registers past the map take the write and change nothing
    wait_idle();
    write_register(REG_IDX_W'(REG_SEG3_LAST + 1), '1);
    write_register(REG_IDX_W'($urandom_range(REG_SEG3_LAST + 2, 14)), POS_W'($urandom_range(0, 63)));
    write_register('1, '0);
    cfg_valid <= 1'b0;
    exercise_segments();
    program_bounds(6'd41, 6'd0, 6'd63, 6'd63, 6'd42, 6'd63, 6'd17, 6'd16);
    exercise_segments();
    program_bounds(POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                   POS_W'($urandom_range(0, 41)), POS_W'($urandom_range(0, 41)),
                   POS_W'($urandom_range(0, 20)), POS_W'($urandom_range(20, 41)),
                   POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)));
    exercise_segments();
  endtask

  task automatic test_fade_sequences();
    while (requests_sent < FADE_GOAL) begin
      run_fade_sequence();
      // now and then hold the sender until the strip is fully drained
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  // raw random requests, spare kinds and off-strip positions included
  task automatic test_random_noise();
    program_bounds(POS_W'($urandom_range(0, 41)), POS_W'($urandom_range(0, 41)),
                   POS_W'($urandom_range(0, 41)), POS_W'($urandom_range(0, 41)),
                   POS_W'($urandom_range(0, 41)), POS_W'($urandom_range(0, 41)),
                   POS_W'($urandom_range(0, 41)), POS_W'($urandom_range(0, 41)));
    while (requests_sent < NOISE_GOAL) send_request(any_fields(KIND_W'($urandom_range(0, 7))));
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_flow();
    calm_run = 1'b1;
    while (requests_sent < STEADY_GOAL) run_fade_sequence();
  endtask

  initial begin
    push       <= 1'b0;
    req_cmd    <= '0;
    pop        <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    pixels_seen   = 0;
    reg_writes    = 0;
    fade_runs     = 0;
    fade_rests    = 0;
    calm_run      = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_requests();
    test_segment_bounds();
    test_fade_sequences();
    test_random_noise();
    test_steady_flow();
    wait_idle();

    $display("run covered %0d requests, %0d pixels checked, %0d register writes",
             requests_sent, pixels_seen, reg_writes);
    $display("fade runs: %0d, of which %0d came to rest", fade_runs, fade_rests);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
